// ----- rtl/mpc_pkg.sv -----
// Shared types and constants for the media presentation clock.
`timescale 1ns / 1ps
package mpc_pkg;

   // Event codes carried in the mode field of an item.
   localparam logic [3:0] MODE_QUERY   = 4'd0;
   localparam logic [3:0] MODE_SET     = 4'd1;
   localparam logic [3:0] MODE_PAUSE   = 4'd2;
   localparam logic [3:0] MODE_RESUME  = 4'd3;
   localparam logic [3:0] MODE_BUF_ON  = 4'd4;
   localparam logic [3:0] MODE_BUF_OFF = 4'd5;
   localparam logic [3:0] MODE_SPEED   = 4'd6;
   localparam logic [3:0] MODE_RESET   = 4'd7;
   localparam logic [3:0] MODE_DIFF    = 4'd8;

   // Register indexes; each register sits at byte address 8*index.
   localparam logic [2:0] REG_AUDIO_DELAY = 3'd0;
   localparam logic [2:0] REG_PLAYER_MODE = 3'd1;
   localparam logic [2:0] REG_SHIFT_EN    = 3'd2;
   localparam logic [2:0] REG_TS_ORIGIN   = 3'd3;
   localparam logic [2:0] REG_TIME_ORIGIN = 3'd4;

   localparam int unsigned ADDR_W = 6;
   localparam int unsigned DATA_W = 64;

   localparam logic [31:0] LOOP_SPAN     = 32'hFFFF_FFFF;
   // Largest quotient that can still be multiplied by 1000 without overflow.
   localparam logic [63:0] RESCALE_LIMIT = 64'd18446744073709551;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

endpackage

// ----- rtl/mpc_divider.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module mpc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mpc_pkg::div_req_type req,
   output mpc_pkg::div_rsp_type rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  count_ff;
   logic [63:0] quo_ff;
   logic [31:0] rem_ff;
   logic [31:0] div_ff;
   logic [32:0] partial;
   logic [32:0] diff;
   logic        fits;

   always_comb begin
      partial = {rem_ff, quo_ff[63]};
      diff    = partial - {1'b0, div_ff};
      fits    = partial >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 6'd1;
            if (count_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[62:0], fits};
         rem_ff <= fits ? diff[31:0] : partial[31:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- rtl/media_presentation_clock.sv -----
// Top level of the event-driven millisecond media clock.
`timescale 1ns / 1ps
// Each accepted item is one clock event and yields exactly one result item that
// shows the clock after the event. The block takes one item at a time. A query,
// pause, resume, buffering, reset or difference event passes through the multiply,
// clock, media and shift states. A speed change passes twice through the multiply
// and clock states, because the elapsed time is scaled by the speed in one shared
// 32x32 multiplier, once before and once after the change. A set-time event on an
// uninitialised clock with a nonzero timescale runs two 64-step divisions on one
// shared restoring divider (timestamp by timescale, then the remainder fraction).
// It then splits the millisecond value into loops by folding its two 32-bit halves.
// The next item can be accepted in the cycle after the result has been accepted.
module media_presentation_clock #(
   parameter int SPEED_FRAC_BITS = 16,
   parameter int NEST_WIDTH      = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [3:0]                  req_mode,
   input  logic [31:0]                 req_wall_ms,
   input  logic [63:0]                 req_ref_ts,
   input  logic [31:0]                 req_timescale,
   input  logic signed [31:0]          req_new_speed,
   input  logic [31:0]                 req_cmp_clock,
   input  logic [31:0]                 req_cmp_stamp,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [31:0]                 rsp_clock_ms,
   output logic [63:0]                 rsp_media_ms,
   output logic [63:0]                 rsp_absolute_ms,
   output logic                        rsp_started,
   output logic signed [31:0]          rsp_stamp_diff,
   output logic [31:0]                 rsp_timeline,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mpc_pkg::ADDR_W-1:0]  paddr,
   input  logic [mpc_pkg::DATA_W-1:0]  pwdata,
   output logic [mpc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DIV1  = 9'b000000010,
      S_DIV2  = 9'b000000100,
      S_DIV3  = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_CLK   = 9'b000100000,
      S_MED   = 9'b001000000,
      S_SHIFT = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   localparam logic [NEST_WIDTH-1:0] NEST_MAX = {NEST_WIDTH{1'b1}};
   localparam logic [31:0] SPEED_ONE = 32'd1 << SPEED_FRAC_BITS;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [16:0] audio_delay_ff, audio_delay_in;
   logic        player_mode_ff, player_mode_in;
   logic        shift_en_ff, shift_en_in;
   logic [63:0] ts_origin_ff, ts_origin_in;
   logic [63:0] time_origin_ff, time_origin_in;

   // Clock state.
   logic                  initialised_ff, initialised_in;
   logic [31:0]           wrap_loops_ff, wrap_loops_in;
   logic [31:0]           init_stamp_ff, init_stamp_in;
   logic [31:0]           start_wall_ff, start_wall_in;
   logic [31:0]           pause_wall_ff, pause_wall_in;
   logic [31:0]           speed_offset_ff, speed_offset_in;
   logic [31:0]           speed_ff, speed_in;
   logic [NEST_WIDTH-1:0] pause_depth_ff, pause_depth_in;
   logic [NEST_WIDTH-1:0] buf_depth_ff, buf_depth_in;
   logic [31:0]           timeline_ff, timeline_in;

   // Per-item working registers.
   logic [31:0] wall_ff, wall_in;
   logic [31:0] new_speed_ff, new_speed_in;
   logic [31:0] scale_ff, scale_in;
   logic        speed_pend_ff, speed_pend_in;
   logic [31:0] diff_ff, diff_in;
   logic [63:0] hi_ff, hi_in;
   logic        sat_ff, sat_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] ck_ff, ck_in;
   logic [63:0] media_ff, media_in;

   // Result registers.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_clock_ff, out_clock_in;
   logic [63:0] out_media_ff, out_media_in;
   logic [63:0] out_abs_ff, out_abs_in;
   logic        out_started_ff, out_started_in;
   logic [31:0] out_diff_ff, out_diff_in;
   logic [31:0] out_timeline_ff, out_timeline_in;

   mpc_pkg::div_req_type div_req;
   mpc_pkg::div_rsp_type div_rsp;

   mpc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   logic cfg_we;
   logic req_fire;
   assign cfg_we   = psel & penable & pwrite;
   assign req_fire = req_valid & req_ready;
   assign pready   = 1'b1;

   always_comb begin
      case (paddr[5:3])
         mpc_pkg::REG_AUDIO_DELAY: prdata = {47'd0, audio_delay_ff};
         mpc_pkg::REG_PLAYER_MODE: prdata = {63'd0, player_mode_ff};
         mpc_pkg::REG_SHIFT_EN:    prdata = {63'd0, shift_en_ff};
         mpc_pkg::REG_TS_ORIGIN:   prdata = ts_origin_ff;
         mpc_pkg::REG_TIME_ORIGIN: prdata = time_origin_ff;
         default:                  prdata = '0;
      endcase
   end

   // Clock time from the registered product and the current state.
   logic [31:0] mag;
   logic [31:0] elapsed;
   logic [31:0] real_t;
   logic [31:0] delay_ext;
   logic        delay_pos;
   logic [31:0] ck_now;
   logic [63:0] stamp_sh;

   always_comb begin
      mag      = speed_ff[31] ? (~speed_ff + 32'd1) : speed_ff;
      elapsed  = (pause_depth_ff != '0 ? pause_wall_ff : wall_ff) - start_wall_ff;
      stamp_sh = {32'd0, init_stamp_ff} << SPEED_FRAC_BITS;
      if (!initialised_ff) begin
         real_t = start_wall_ff;
      end else if (speed_ff[31]) begin
         if (init_stamp_ff[31] || stamp_sh < prod_ff) begin
            real_t = '0;
         end else begin
            real_t = speed_offset_ff + init_stamp_ff - prod_ff[SPEED_FRAC_BITS +: 32];
         end
      end else begin
         real_t = speed_offset_ff + init_stamp_ff + prod_ff[SPEED_FRAC_BITS +: 32];
      end
      delay_ext = {{15{audio_delay_ff[16]}}, audio_delay_ff};
      delay_pos = !audio_delay_ff[16] && audio_delay_ff != '0;
      ck_now    = (delay_pos && real_t < delay_ext) ? 32'd0 : real_t - delay_ext;
   end

   always_comb begin
      logic [NEST_WIDTH-1:0] pd;
      logic [NEST_WIDTH-1:0] bd;
      logic [31:0]           pw;
      logic [31:0]           sw;
      logic [31:0]           dd;
      logic [64:0]           sum;
      logic [63:0]           ms;
      logic [63:0]           q;
      logic [41:0]           r1000;
      logic [63:0]           shifted;
      logic [32:0]           fold;
      logic [32:0]           loops_w;
      logic [31:0]           stamp_w;

      state_in        = state_ff;
      audio_delay_in  = audio_delay_ff;
      player_mode_in  = player_mode_ff;
      shift_en_in     = shift_en_ff;
      ts_origin_in    = ts_origin_ff;
      time_origin_in  = time_origin_ff;
      initialised_in  = initialised_ff;
      wrap_loops_in   = wrap_loops_ff;
      init_stamp_in   = init_stamp_ff;
      start_wall_in   = start_wall_ff;
      pause_wall_in   = pause_wall_ff;
      speed_offset_in = speed_offset_ff;
      speed_in        = speed_ff;
      pause_depth_in  = pause_depth_ff;
      buf_depth_in    = buf_depth_ff;
      timeline_in     = timeline_ff;
      wall_in         = wall_ff;
      new_speed_in    = new_speed_ff;
      scale_in        = scale_ff;
      speed_pend_in   = speed_pend_ff;
      diff_in         = diff_ff;
      hi_in           = hi_ff;
      sat_in          = sat_ff;
      prod_in         = prod_ff;
      ck_in           = ck_ff;
      media_in        = media_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_clock_in    = out_clock_ff;
      out_media_in    = out_media_ff;
      out_abs_in      = out_abs_ff;
      out_started_in  = out_started_ff;
      out_diff_in     = out_diff_ff;
      out_timeline_in = out_timeline_ff;
      div_req         = '0;

      pd      = pause_depth_ff;
      bd      = buf_depth_ff;
      pw      = pause_wall_ff;
      sw      = start_wall_ff;
      dd      = '0;
      q       = div_rsp.quotient;
      r1000   = ({10'd0, div_rsp.remainder} << 10) - ({10'd0, div_rsp.remainder} << 4)
              - ({10'd0, div_rsp.remainder} << 3);
      sum     = {1'b0, hi_ff} + {1'b0, div_rsp.quotient};
      ms      = (sat_ff || sum[64]) ? {64{1'b1}} : sum[63:0];
      shifted = (media_ff > ts_origin_ff) ? media_ff - ts_origin_ff : 64'd0;

      // Since 2^32 is one more than the loop span, the value held in hi_ff splits
      // into loops and a remainder by adding its halves and reducing the sum by
      // at most two spans.
      fold = {1'b0, hi_ff[63:32]} + {1'b0, hi_ff[31:0]};
      if (fold >= {mpc_pkg::LOOP_SPAN, 1'b0}) begin
         loops_w = {1'b0, hi_ff[63:32]} + 33'd2;
         stamp_w = '0;
      end else if (fold >= {1'b0, mpc_pkg::LOOP_SPAN}) begin
         // Subtracting 2^32-1 is dropping the top bit and adding one.
         loops_w = {1'b0, hi_ff[63:32]} + 33'd1;
         stamp_w = fold[31:0] + 32'd1;
      end else begin
         loops_w = {1'b0, hi_ff[63:32]};
         stamp_w = fold[31:0];
      end

      if (cfg_we) begin
         case (paddr[5:3])
            mpc_pkg::REG_AUDIO_DELAY: audio_delay_in = pwdata[16:0];
            mpc_pkg::REG_PLAYER_MODE: player_mode_in = pwdata[0];
            mpc_pkg::REG_SHIFT_EN:    shift_en_in    = pwdata[0];
            mpc_pkg::REG_TS_ORIGIN:   ts_origin_in   = pwdata;
            mpc_pkg::REG_TIME_ORIGIN: time_origin_in = pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               wall_in       = req_wall_ms;
               new_speed_in  = $unsigned(req_new_speed);
               scale_in      = req_timescale;
               speed_pend_in = 1'b0;
               diff_in       = '0;
               state_in      = S_MUL;
               case (req_mode)
                  mpc_pkg::MODE_SET: begin
                     if (!initialised_ff) begin
                        if (req_timescale == '0) begin
                           initialised_in = 1'b1;
                           wrap_loops_in  = '0;
                           init_stamp_in  = '0;
                           audio_delay_in = '0;
                           start_wall_in  = req_wall_ms;
                           pause_wall_in  = req_wall_ms;
                        end else begin
                           div_req.start    = 1'b1;
                           div_req.dividend = req_ref_ts;
                           div_req.divisor  = req_timescale;
                           state_in         = S_DIV1;
                        end
                     end
                  end
                  mpc_pkg::MODE_PAUSE: begin
                     if (pd == '0) pw = req_wall_ms;
                     if (pd != NEST_MAX) pd = pd + 1'b1;
                  end
                  mpc_pkg::MODE_RESUME: begin
                     if (pd != '0) pd = pd - 1'b1;
                     if (pd == '0 && player_mode_ff) sw = sw + (req_wall_ms - pw);
                  end
                  mpc_pkg::MODE_BUF_ON: begin
                     if (bd == '0) begin
                        if (pd == '0) pw = req_wall_ms;
                        if (pd != NEST_MAX) pd = pd + 1'b1;
                     end
                     if (bd != NEST_MAX) bd = bd + 1'b1;
                  end
                  mpc_pkg::MODE_BUF_OFF: begin
                     if (bd != '0) begin
                        bd = bd - 1'b1;
                        if (bd == '0) begin
                           if (pd != '0) pd = pd - 1'b1;
                           if (pd == '0 && player_mode_ff) sw = sw + (req_wall_ms - pw);
                        end
                     end
                  end
                  mpc_pkg::MODE_SPEED: begin
                     speed_pend_in = ($unsigned(req_new_speed) != speed_ff);
                  end
                  mpc_pkg::MODE_RESET: begin
                     initialised_in  = 1'b0;
                     audio_delay_in  = '0;
                     speed_offset_in = '0;
                     init_stamp_in   = '0;
                     sw              = '0;
                     shift_en_in     = 1'b0;
                     timeline_in     = timeline_ff + 32'd1;
                  end
                  mpc_pkg::MODE_DIFF: begin
                     // The span across a 32-bit wrap is 2^32-1, so it shifts
                     // the raw difference by one in either direction.
                     dd = req_cmp_stamp - req_cmp_clock;
                     if (req_cmp_clock[31] && !req_cmp_stamp[31]) begin
                        dd = dd - 32'd1;
                     end else if (!req_cmp_clock[31] && req_cmp_stamp[31]) begin
                        dd = dd + 32'd1;
                     end
                     if (speed_ff[31]) dd = ~dd + 32'd1;
                     diff_in = dd;
                  end
                  default: ;
               endcase
               if (req_mode != mpc_pkg::MODE_SET) begin
                  pause_depth_in = pd;
                  buf_depth_in   = bd;
                  pause_wall_in  = pw;
                  start_wall_in  = sw;
               end
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               sat_in           = q > mpc_pkg::RESCALE_LIMIT;
               hi_in            = (q << 10) - (q << 4) - (q << 3);
               div_req.start    = 1'b1;
               div_req.dividend = {22'd0, r1000};
               div_req.divisor  = scale_ff;
               state_in         = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               hi_in    = ms;
               state_in = S_DIV3;
            end
         end
         S_DIV3: begin
            wrap_loops_in  = loops_w[32] ? 32'hFFFF_FFFF : loops_w[31:0];
            init_stamp_in  = stamp_w;
            initialised_in = 1'b1;
            audio_delay_in = '0;
            start_wall_in  = wall_ff;
            pause_wall_in  = wall_ff;
            state_in       = S_MUL;
         end
         S_MUL: begin
            prod_in  = {32'd0, mag} * {32'd0, elapsed};
            state_in = S_CLK;
         end
         S_CLK: begin
            if (speed_pend_ff) begin
               // A speed change rebases the clock at the current time, then
               // the result is computed again under the new speed.
               speed_offset_in = ck_now - init_stamp_ff;
               start_wall_in   = wall_ff;
               pause_wall_in   = wall_ff;
               speed_in        = new_speed_ff;
               speed_pend_in   = 1'b0;
               state_in        = S_MUL;
            end else begin
               ck_in    = ck_now;
               state_in = S_MED;
            end
         end
         S_MED: begin
            media_in = {wrap_loops_ff, 32'd0} - {32'd0, wrap_loops_ff} + {32'd0, ck_ff};
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            out_clock_in    = ck_ff;
            out_media_in    = shift_en_ff ? shifted + time_origin_ff : media_ff;
            out_abs_in      = initialised_ff ? media_ff : 64'd0;
            out_started_in  = initialised_ff && buf_depth_ff == '0 && pause_depth_ff == '0;
            out_diff_in     = diff_ff;
            out_timeline_in = timeline_ff;
            rsp_valid_in    = 1'b1;
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         audio_delay_ff  <= '0;
         player_mode_ff  <= 1'b1;
         shift_en_ff     <= 1'b0;
         ts_origin_ff    <= '0;
         time_origin_ff  <= '0;
         initialised_ff  <= 1'b0;
         wrap_loops_ff   <= '0;
         init_stamp_ff   <= '0;
         start_wall_ff   <= '0;
         pause_wall_ff   <= '0;
         speed_offset_ff <= '0;
         speed_ff        <= SPEED_ONE;
         pause_depth_ff  <= '0;
         buf_depth_ff    <= '0;
         timeline_ff     <= 32'd1;
         speed_pend_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         audio_delay_ff  <= audio_delay_in;
         player_mode_ff  <= player_mode_in;
         shift_en_ff     <= shift_en_in;
         ts_origin_ff    <= ts_origin_in;
         time_origin_ff  <= time_origin_in;
         initialised_ff  <= initialised_in;
         wrap_loops_ff   <= wrap_loops_in;
         init_stamp_ff   <= init_stamp_in;
         start_wall_ff   <= start_wall_in;
         pause_wall_ff   <= pause_wall_in;
         speed_offset_ff <= speed_offset_in;
         speed_ff        <= speed_in;
         pause_depth_ff  <= pause_depth_in;
         buf_depth_ff    <= buf_depth_in;
         timeline_ff     <= timeline_in;
         speed_pend_ff   <= speed_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wall_ff         <= wall_in;
      new_speed_ff    <= new_speed_in;
      scale_ff        <= scale_in;
      diff_ff         <= diff_in;
      hi_ff           <= hi_in;
      sat_ff          <= sat_in;
      prod_ff         <= prod_in;
      ck_ff           <= ck_in;
      media_ff        <= media_in;
      out_clock_ff    <= out_clock_in;
      out_media_ff    <= out_media_in;
      out_abs_ff      <= out_abs_in;
      out_started_ff  <= out_started_in;
      out_diff_ff     <= out_diff_in;
      out_timeline_ff <= out_timeline_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_clock_ms    = out_clock_ff;
   assign rsp_media_ms    = out_media_ff;
   assign rsp_absolute_ms = out_abs_ff;
   assign rsp_started     = out_started_ff;
   assign rsp_stamp_diff  = $signed(out_diff_ff);
   assign rsp_timeline    = out_timeline_ff;

endmodule
